@@ design/lesmp_pkg.sv @@
package lesmp_pkg;

    localparam int LANES  = 8;
    localparam int LANE_W = 3;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_HALF  = 2'd1;
    localparam logic [1:0] SIZE_WORD  = 2'd2;
    localparam logic [1:0] SIZE_DWORD = 2'd3;

    localparam logic [16:0] LIMIT_RESET = 17'd65536;

    typedef logic [7:0] t_byte;

    // read in flight between bank access and output register
    typedef struct packed {
        logic              rd;
        logic              err;
        logic [LANE_W-1:0] shift;
        logic [1:0]        size;
    } t_s1_ctrl;

    function automatic logic [3:0] size_bytes(input logic [1:0] size);
        logic [3:0] n;
        case (size)
            SIZE_BYTE:  n = 4'd1;
            SIZE_HALF:  n = 4'd2;
            SIZE_WORD:  n = 4'd4;
            SIZE_DWORD: n = 4'd8;
            default:    n = 4'd1;
        endcase
        return n;
    endfunction

endpackage

@@ design/lesmp_bank.sv @@
module lesmp_bank
    import lesmp_pkg::*;
#(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  t_byte             i_wdata,
    output t_byte             o_rdata
);

    t_byte r_mem [DEPTH];
    t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/lesmp_lane_map.sv @@
module lesmp_lane_map
    import lesmp_pkg::*;
#(
    parameter int ROW_W = 13
) (
    input  logic [LANE_W-1:0]            i_offset,
    input  logic [ROW_W-1:0]             i_row_base,
    input  logic [1:0]                   i_size,
    input  logic [63:0]                  i_write_value,
    output logic [LANES-1:0]             o_used,
    output logic [LANES-1:0][ROW_W-1:0]  o_row,
    output logic [LANES-1:0][7:0]        o_wdata
);

    logic [3:0] nbytes;

    assign nbytes = size_bytes(i_size);

    // bank b carries byte (b - offset) mod 8 of the word
    always_comb begin
        for (int b = 0; b < LANES; b++) begin
            logic [LANE_W-1:0] idx;
            logic [63:0]       sh;
            idx        = LANE_W'(b) - i_offset;
            sh         = i_write_value >> {idx, 3'b000};
            o_used[b]  = {1'b0, idx} < nbytes;
            o_row[b]   = i_row_base + ROW_W'(LANE_W'(b) < i_offset);
            o_wdata[b] = sh[7:0];
        end
    end

endmodule

@@ design/lesmp_align.sv @@
module lesmp_align
    import lesmp_pkg::*;
(
    input  t_s1_ctrl           i_ctrl,
    input  logic [LANES-1:0][7:0] i_bank_data,
    output logic [63:0]        o_read_value
);

    logic [3:0] nbytes;

    assign nbytes = size_bytes(i_ctrl.size);

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            logic [LANE_W-1:0] lane;
            lane = i_ctrl.shift + LANE_W'(i);
            if (i_ctrl.rd && (4'(i) < nbytes)) begin
                o_read_value[8*i +: 8] = i_bank_data[lane];
            end else begin
                o_read_value[8*i +: 8] = 8'h00;
            end
        end
    end

endmodule

@@ design/little_endian_sized_memory_port.sv @@
// Byte-addressable little-endian memory, 1/2/4/8-byte accesses at any address.
// Input channel: i_in_valid / o_in_stall with action, size, address and write
// data; a word is taken when valid is high and stall is low. Output channel:
// o_out_valid / i_out_stall with read_value and range_error, one result per
// input word, in order. Writes return zero data.
// Storage is eight byte-wide banks; an unaligned access touches each bank at
// most once, so every access is one parallel bank access. An accepted word
// passes through the bank read stage and then the output register; throughput
// is one word per cycle while the output is not stalled. A stalled result
// holds, one more word may be in flight behind it, then the input stalls.
// After reset the banks are swept to zero, one row per cycle, over all
// BANK_DEPTH rows (8192 at the default); the input stalls meanwhile.
// i_cfg_we writes the memory limit (reset 65536, saturated at capacity); an
// access whose end passes the limit reports range_error and changes nothing.
module little_endian_sized_memory_port
    import lesmp_pkg::*;
#(
    parameter int CAPACITY_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [1:0]  i_access_size,
    input  logic [31:0] i_byte_address,
    input  logic [63:0] i_write_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_read_value,
    output logic        o_range_error
);

    localparam int BANK_DEPTH = (CAPACITY_BYTES + LANES - 1) / LANES;
    localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    logic [16:0]      r_mem_limit;
    logic             r_clear_busy;
    logic [ROW_W-1:0] r_clear_row;
    logic             r_s1_valid;
    t_s1_ctrl         r_s1_ctrl;
    logic             r_out_valid;
    logic [63:0]      r_out_value;
    logic             r_out_err;

    logic             n_clear_busy;
    logic [ROW_W-1:0] n_clear_row;
    t_s1_ctrl         n_s1_ctrl;

    logic                        s1_adv;
    logic                        in_ok;
    logic                        accept;
    logic [32:0]                 end_addr;
    logic [32:0]                 eff_limit;
    logic                        err;
    logic [LANES-1:0]            used;
    logic [LANES-1:0][ROW_W-1:0] lane_row;
    logic [LANES-1:0][7:0]       lane_wdata;
    logic [LANES-1:0][7:0]       bank_rdata;
    logic [63:0]                 rd_value;

    assign s1_adv = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign in_ok  = !r_clear_busy && (!r_s1_valid || s1_adv);
    assign accept = i_in_valid && in_ok;
    assign o_in_stall = !in_ok;

    assign eff_limit = ({16'd0, r_mem_limit} < 33'(CAPACITY_BYTES)) ?
                       {16'd0, r_mem_limit} : 33'(CAPACITY_BYTES);
    assign end_addr  = {1'b0, i_byte_address} + 33'(size_bytes(i_access_size));
    assign err       = end_addr > eff_limit;

    lesmp_lane_map #(
        .ROW_W(ROW_W)
    ) u_lane_map (
        .i_offset      (i_byte_address[LANE_W-1:0]),
        .i_row_base    (i_byte_address[ROW_W+LANE_W-1:LANE_W]),
        .i_size        (i_access_size),
        .i_write_value (i_write_value),
        .o_used        (used),
        .o_row         (lane_row),
        .o_wdata       (lane_wdata)
    );

    for (genvar b = 0; b < LANES; b++) begin : g_bank
        logic       bk_en;
        logic       bk_we;
        logic [ROW_W-1:0] bk_addr;
        t_byte      bk_wdata;

        assign bk_we    = r_clear_busy ||
                          (accept && (i_action == ACT_WRITE) && !err && used[b]);
        assign bk_en    = r_clear_busy || (accept && (i_action == ACT_READ)) || bk_we;
        assign bk_addr  = r_clear_busy ? r_clear_row : lane_row[b];
        assign bk_wdata = r_clear_busy ? 8'h00 : lane_wdata[b];

        lesmp_bank #(
            .DEPTH  (BANK_DEPTH),
            .ADDR_W (ROW_W)
        ) u_bank (
            .i_clk   (i_clk),
            .i_en    (bk_en),
            .i_we    (bk_we),
            .i_addr  (bk_addr),
            .i_wdata (bk_wdata),
            .o_rdata (bank_rdata[b])
        );
    end

    lesmp_align u_align (
        .i_ctrl       (r_s1_ctrl),
        .i_bank_data  (bank_rdata),
        .o_read_value (rd_value)
    );

    always_comb begin
        n_clear_busy = r_clear_busy;
        n_clear_row  = r_clear_row;
        if (r_clear_busy) begin
            n_clear_row = r_clear_row + ROW_W'(1);
            if (r_clear_row == ROW_W'(BANK_DEPTH - 1)) begin
                n_clear_busy = 1'b0;
            end
        end
    end

    always_comb begin
        n_s1_ctrl.rd    = (i_action == ACT_READ) && !err;
        n_s1_ctrl.err   = err;
        n_s1_ctrl.shift = i_byte_address[LANE_W-1:0];
        n_s1_ctrl.size  = i_access_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_limit  <= LIMIT_RESET;
            r_clear_busy <= 1'b1;
            r_clear_row  <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mem_limit <= i_cfg_wdata;
            end
            r_clear_busy <= n_clear_busy;
            r_clear_row  <= n_clear_row;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctrl <= n_s1_ctrl;
        end
        if (s1_adv) begin
            r_out_value <= rd_value;
            r_out_err   <= r_s1_ctrl.err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_out_value;
    assign o_range_error = r_out_err;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clear_busy |-> !accept)
        else $error("word accepted during bank clear");

    a_err_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |-> o_read_value == 64'd0)
        else $error("range error with nonzero data");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_ctrl))
        else $error("stalled bank read lost");

    a_accept_reaches_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted word not in flight");

    a_out_fed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> o_out_valid)
        else $error("result dropped");

endmodule
